// File: rtl/arpc_pkg.sv
`default_nettype none

package arpc_pkg;

  // Table geometry.
  localparam int ENTRIES = 128;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // Field widths fixed by the interface.
  localparam int IP_W    = 32;
  localparam int MAC_W   = 48;
  localparam int AGE_W   = 16;
  localparam int SLOT_W  = 7;
  localparam int EXP_W   = 8;

  localparam logic [AGE_W-1:0] AGE_MAX        = '1;
  localparam logic [EXP_W-1:0] EXP_MAX        = '1;
  localparam logic [AGE_W-1:0] TIMEOUT_RESET  = 16'd15;

  // Configuration register map.
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] ADDR_TIMEOUT = 2'd0;

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_TICK   = 2'd2,
    MODE_RSVD   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
    logic [AGE_W-1:0] age;
  } entry_t;

  typedef struct packed {
    logic             ip_match;
    logic [AGE_W-1:0] age_inc;
    logic             aged_out;
  } unit_res_t;

  typedef struct packed {
    logic              found;
    logic [MAC_W-1:0]  mac_found;
    logic              stored;
    logic [SLOT_W-1:0] slot_index;
    logic [EXP_W-1:0]  expired_count;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/arpc_ram.sv
`default_nettype none

module arpc_ram
  import arpc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire entry_t           wr_data,
  input  wire logic [IDX_W-1:0] rd_addr,
  output entry_t                rd_data_r
);

  entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: rtl/arpc_unit.sv
`default_nettype none

module arpc_unit
  import arpc_pkg::*;
(
  input  wire entry_t           entry,
  input  wire logic [IP_W-1:0]  ip,
  input  wire logic [AGE_W-1:0] timeout,
  output unit_res_t             res
);

  // One entry is examined per cycle: address compare for lookups,
  // saturating age increment and expiry compare for ticks.
  always_comb begin
    res.ip_match = (entry.ip == ip);
    res.age_inc  = (entry.age != AGE_MAX) ? entry.age + 1'b1 : entry.age;
    res.aged_out = (res.age_inc > timeout);
  end

endmodule

`default_nettype wire

// File: rtl/arpc_seq.sv
`default_nettype none

module arpc_seq
  import arpc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [1:0]       in_mode,
  input  wire logic [IP_W-1:0]  in_ip,
  input  wire logic [MAC_W-1:0] in_mac,
  input  wire logic [AGE_W-1:0] timeout,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output result_t               res
);

  state_t             state_r, state_nxt;
  mode_t              mode_r;
  logic [IP_W-1:0]    ip_r;
  logic [MAC_W-1:0]   mac_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               p_vld_r;
  logic [IDX_W-1:0]   p_idx_r;
  logic               hit_r;
  logic [IDX_W-1:0]   slot_r;
  logic [MAC_W-1:0]   macf_r;
  logic [EXP_W-1:0]   exp_r;
  logic [ENTRIES-1:0] valid_r;

  logic               accept;
  logic               issue;
  logic               scan_end;
  logic               p_valid;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;
  entry_t             rd_data;
  unit_res_t          ures;

  arpc_ram u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (cnt_r[IDX_W-1:0]),
    .rd_data_r (rd_data)
  );

  arpc_unit u_unit (
    .entry   (rd_data),
    .ip      (ip_r),
    .timeout (timeout),
    .res     (ures)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (mode_t'(in_mode) == MODE_RSVD) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and per-cycle controls.
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    accept    = (state_r == ST_IDLE) && in_valid;
    issue     = (state_r == ST_SCAN) && (cnt_r < CNT_W'(ENTRIES));
    scan_end  = (state_r == ST_SCAN) && (cnt_r == CNT_W'(ENTRIES)) && !p_vld_r;
    p_valid   = p_vld_r && valid_r[p_idx_r];
    res_valid = (state_r == ST_DONE);

    wr_en   = 1'b0;
    wr_addr = p_idx_r;
    wr_data = '{ip: rd_data.ip, mac: rd_data.mac, age: ures.age_inc};
    if (p_valid && mode_r == MODE_TICK) begin
      wr_en = 1'b1;
    end else if (scan_end && mode_r == MODE_INSERT && hit_r) begin
      wr_en   = 1'b1;
      wr_addr = slot_r;
      wr_data = '{ip: ip_r, mac: mac_r, age: '0};
    end

    res.found         = hit_r && (mode_r == MODE_LOOKUP);
    res.mac_found     = macf_r;
    res.stored        = hit_r && (mode_r == MODE_INSERT);
    res.slot_index    = hit_r ? SLOT_W'(slot_r) : '0;
    res.expired_count = exp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      p_vld_r <= 1'b0;
      valid_r <= '0;
      hit_r   <= 1'b0;
      exp_r   <= '0;
      mode_r  <= MODE_LOOKUP;
    end else begin
      state_r <= state_nxt;
      p_vld_r <= issue;
      if (accept) begin
        mode_r <= mode_t'(in_mode);
        hit_r  <= 1'b0;
        exp_r  <= '0;
      end
      if (p_vld_r) begin
        case (mode_r)
          MODE_LOOKUP: begin
            if (p_valid && ures.ip_match) begin
              hit_r <= 1'b1;
            end
          end
          MODE_INSERT: begin
            if (!valid_r[p_idx_r]) begin
              hit_r <= 1'b1;
            end
          end
          MODE_TICK: begin
            if (p_valid && ures.aged_out) begin
              valid_r[p_idx_r] <= 1'b0;
              if (exp_r != EXP_MAX) begin
                exp_r <= exp_r + 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      if (scan_end && mode_r == MODE_INSERT && hit_r) begin
        valid_r[slot_r] <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      ip_r   <= in_ip;
      mac_r  <= in_mac;
      cnt_r  <= '0;
      slot_r <= '0;
      macf_r <= '0;
    end else if (issue) begin
      cnt_r <= cnt_r + 1'b1;
    end
    p_idx_r <= cnt_r[IDX_W-1:0];
    if (p_vld_r) begin
      if (mode_r == MODE_LOOKUP && p_valid && ures.ip_match) begin
        slot_r <= p_idx_r;
        macf_r <= rd_data.mac;
      end else if (mode_r == MODE_INSERT && !valid_r[p_idx_r] && !hit_r) begin
        slot_r <= p_idx_r;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    p_vld_r |-> (state_r == ST_SCAN))
    else $error("entry processed outside a scan");

  a_write_target: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> ((mode_r == MODE_TICK) ? valid_r[wr_addr] : !valid_r[wr_addr]))
    else $error("table write to the wrong kind of slot");

  a_expire_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
    (exp_r != '0) |-> (mode_r == MODE_TICK))
    else $error("expiry count outside a tick");

  a_valid_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && state_r != ST_SCAN) |=> $stable(valid_r))
    else $error("valid bits changed outside a scan");
`endif

endmodule

`default_nettype wire

// File: rtl/arp_cache_table.sv
// A lookup, insert or tick scans every slot of the entry memory, from acceptance until its
// result is held in the output register; an unused mode skips the scan.
// A new transaction is accepted only once the last has left the sequencer, and the scan of
// the entry memory runs through its single read port, one slot per cycle through the unit.
// Reset (synchronous, active low) clears every valid bit at once and sets the timeout
// to 15; the address, MAC and age memory is not cleared, so no clearing pass is needed.
`default_nettype none

module arp_cache_table
  import arpc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            in_mode,
  input  wire logic [IP_W-1:0]       in_ip_address,
  input  wire logic [MAC_W-1:0]      in_mac_address,

  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_found,
  output logic [MAC_W-1:0]           out_mac_found,
  output logic                       out_stored,
  output logic [SLOT_W-1:0]          out_slot_index,
  output logic [EXP_W-1:0]           out_expired_count,

  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0]      cfg_prdata,
  output logic                       cfg_pready
);

  // The timeout register. Software must write it only while the table is idle, so that the
  // scan sees a steady value for the whole of a tick; the block itself does not enforce this.
  logic [AGE_W-1:0] timeout_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_wr && cfg_paddr == ADDR_TIMEOUT) begin
      timeout_r <= cfg_pwdata[AGE_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == ADDR_TIMEOUT) begin
      cfg_prdata = CFG_DATA_W'(timeout_r);
    end
  end

  // The sequencer accepts one transaction at a time and holds its result
  // until the output register below can take it.
  result_t res;
  logic    res_valid;
  logic    res_ready;
  logic    res_take;

  arpc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_mode   (in_mode),
    .in_ip     (in_ip_address),
    .in_mac    (in_mac_address),
    .timeout   (timeout_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register. It separates the two sides: a result waiting here does
  // not stop the sequencer from accepting and scanning the next transaction.
  logic    out_valid_r;
  result_t out_r;

  assign res_ready = !out_valid_r || !out_stall;
  assign res_take  = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_r.found;
  assign out_mac_found     = out_r.mac_found;
  assign out_stored        = out_r.stored;
  assign out_slot_index    = out_r.slot_index;
  assign out_expired_count = out_r.expired_count;

endmodule

`default_nettype wire

// File: tb/tb_arp_cache_table.sv
`timescale 1ns / 1ps

// Shadow copy of the address table. Every accepted request is applied to the shadow
// as soon as it is taken, and the answer it must produce is queued. Answers leave the
// block in request order, so each returned answer is matched against the oldest one.
class arp_lookup_tracker;
  logic [arpc_pkg::AGE_W-1:0] timeout_s;
  bit                         slot_live [arpc_pkg::ENTRIES];
  logic [arpc_pkg::IP_W-1:0]  slot_ip   [arpc_pkg::ENTRIES];
  logic [arpc_pkg::MAC_W-1:0] slot_mac  [arpc_pkg::ENTRIES];
  logic [arpc_pkg::AGE_W-1:0] slot_age  [arpc_pkg::ENTRIES];
  arpc_pkg::result_t          pending_answers [$];
  int                         mismatches;

  function new();
    timeout_s = arpc_pkg::TIMEOUT_RESET;
    foreach (slot_live[i]) slot_live[i] = 1'b0;
    mismatches = 0;
  endfunction

  function void take_request(arpc_pkg::mode_t mode, logic [arpc_pkg::IP_W-1:0] ip,
                             logic [arpc_pkg::MAC_W-1:0] mac);
    arpc_pkg::result_t ans;
    int                free_slot;
    int                gone;
    ans       = '0;
    free_slot = -1;
    gone      = 0;
    case (mode)
      arpc_pkg::MODE_LOOKUP: begin
        // Scanning upwards lets the highest matching slot overwrite earlier hits.
        for (int i = 0; i < arpc_pkg::ENTRIES; i++) begin
          if (slot_live[i] && slot_ip[i] == ip) begin
            ans.found      = 1'b1;
            ans.mac_found  = slot_mac[i];
            ans.slot_index = arpc_pkg::SLOT_W'(i);
          end
        end
      end
      arpc_pkg::MODE_INSERT: begin
        for (int i = 0; i < arpc_pkg::ENTRIES; i++) begin
          if (!slot_live[i] && free_slot < 0) free_slot = i;
        end
        if (free_slot >= 0) begin
          slot_live[free_slot] = 1'b1;
          slot_ip[free_slot]   = ip;
          slot_mac[free_slot]  = mac;
          slot_age[free_slot]  = '0;
          ans.stored           = 1'b1;
          ans.slot_index       = arpc_pkg::SLOT_W'(free_slot);
        end
      end
      arpc_pkg::MODE_TICK: begin
        for (int i = 0; i < arpc_pkg::ENTRIES; i++) begin
          if (slot_live[i]) begin
            if (slot_age[i] != arpc_pkg::AGE_MAX) slot_age[i] = slot_age[i] + 1'b1;
            if (slot_age[i] > timeout_s) begin
              slot_live[i] = 1'b0;
              if (gone < int'(arpc_pkg::EXP_MAX)) gone++;
            end
          end
        end
        ans.expired_count = arpc_pkg::EXP_W'(gone);
      end
      default: begin
      end
    endcase
    pending_answers.push_back(ans);
  endfunction

  function void check_answer(arpc_pkg::result_t got);
    arpc_pkg::result_t want;
    bit                bad;
    if (pending_answers.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("answer with no request outstanding: %p", got);
      return;
    end
    want = pending_answers.pop_front();
    bad  = (got.found !== want.found) || (got.mac_found !== want.mac_found) ||
           (got.stored !== want.stored) || (got.slot_index !== want.slot_index) ||
           (got.expired_count !== want.expired_count);
    if (bad) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("answer differs: found %0b/%0b mac %h/%h stored %0b/%0b slot %0d/%0d expired %0d/%0d",
                 want.found, got.found, want.mac_found, got.mac_found, want.stored, got.stored,
                 want.slot_index, got.slot_index, want.expired_count, got.expired_count);
      end
    end
  endfunction
endclass

module tb_arp_cache_table
  import arpc_pkg::*;
();

  // Generous ceiling: far above the slowest legal run, with every transaction waiting out
  // the longest source gap and the longest sink stall on top of its full table scan.
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int POOL        = 24;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            in_mode;
  logic [IP_W-1:0]       in_ip_address;
  logic [MAC_W-1:0]      in_mac_address;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_found;
  logic [MAC_W-1:0]      out_mac_found;
  logic                  out_stored;
  logic [SLOT_W-1:0]     out_slot_index;
  logic [EXP_W-1:0]      out_expired_count;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  arp_lookup_tracker     tracker;
  logic [IP_W-1:0]       ip_pool [POOL];
  bit                    quiet_src  = 1'b0;
  bit                    quiet_sink = 1'b0;
  int                    cycles     = 0;

  arp_cache_table dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_ip_address     (in_ip_address),
    .in_mac_address    (in_mac_address),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_found         (out_found),
    .out_mac_found     (out_mac_found),
    .out_stored        (out_stored),
    .out_slot_index    (out_slot_index),
    .out_expired_count (out_expired_count),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The watchdog. Hitting it means the block has hung or is far slower than it should be.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Monitor. All stimulus is driven with nonblocking assignments at the rising edge, so
  // the values seen here are those that were stable just before the edge. A register
  // write updates the shadow timeout, an accepted request updates the shadow table and
  // queues its answer, and an accepted answer is checked against the oldest one queued.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == ADDR_TIMEOUT) begin
        tracker.timeout_s = cfg_pwdata[AGE_W-1:0];
      end
      if (in_valid && !in_stall) begin
        tracker.take_request(mode_t'(in_mode), in_ip_address, in_mac_address);
      end
      if (out_valid && !out_stall) begin
        tracker.check_answer({out_found, out_mac_found, out_stored, out_slot_index,
                              out_expired_count});
      end
    end
  end

  // Sink back-pressure: mostly short stalls, now and then a long one, and none at all
  // while quiet_sink is set.
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (quiet_sink || $urandom_range(0, 99) < 75) begin
        out_stall <= 1'b0;
      end else begin
        hold = ($urandom_range(0, 9) == 0) ? int'($urandom_range(40, 300))
                                           : int'($urandom_range(1, 4));
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Source idle time between transactions: usually none or short, rarely long.
  function automatic int source_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet_src || roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 4);
    if (roll < 97) return $urandom_range(5, 30);
    return $urandom_range(100, 400);
  endfunction

  // Most addresses come from a small pool so that lookups hit and inserts duplicate.
  function automatic logic [IP_W-1:0] pick_ip();
    if ($urandom_range(0, 3) != 0) return ip_pool[$urandom_range(0, POOL - 1)];
    return $urandom();
  endfunction

  function automatic logic [MAC_W-1:0] pick_mac();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[MAC_W-1:0];
  endfunction

  // Offers one transaction and returns in the time step of the edge that accepted it.
  // Valid stays high into the next transaction when no gap follows, so it is never
  // lowered and raised within one step.
  task automatic send(mode_t mode, logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
    int gap;
    gap = source_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_ip_address  <= ip;
    in_mac_address <= mac;
    do @(posedge clk); while (in_stall);
  endtask

  // Holds the source off until every queued answer has come back. The first edge lets
  // the monitor record the transaction that was accepted just before the call. Every
  // transaction yields an answer, so a short margin afterwards is enough.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write: a setup phase, then an access phase that completes with pready.
  task automatic write_timeout(logic [AGE_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_TIMEOUT;
    cfg_pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // A run of random transactions. The weights are percentages for insert, lookup and
  // tick; whatever is left over goes to the unused mode.
  task automatic run_mix(int count, int w_ins, int w_look, int w_tick);
    int    roll;
    mode_t mode;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < w_ins)                       mode = MODE_INSERT;
      else if (roll < w_ins + w_look)         mode = MODE_LOOKUP;
      else if (roll < w_ins + w_look + w_tick) mode = MODE_TICK;
      else                                    mode = MODE_RSVD;
      send(mode, pick_ip(), pick_mac());
    end
  endtask

  initial begin
    tracker        = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_mode        = MODE_LOOKUP;
    in_ip_address  = '0;
    in_mac_address = '0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    ip_pool[0]     = '0;
    ip_pool[1]     = '1;
    for (int i = 2; i < POOL; i++) ip_pool[i] = $urandom();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, timeout at its reset value. An empty table must miss and expire
    // nothing; the unused mode must answer with all zeros and leave the table alone.
    send(MODE_LOOKUP, '0, '0);
    send(MODE_RSVD, '1, '1);
    send(MODE_TICK, '0, '0);
    // Extreme addresses, then a duplicate of address zero: the later copy must win.
    send(MODE_INSERT, '0, '0);
    send(MODE_INSERT, '1, '1);
    send(MODE_INSERT, '0, 48'h0123_4567_89ab);
    send(MODE_LOOKUP, '0, '1);
    send(MODE_LOOKUP, '1, '0);
    send(MODE_LOOKUP, 32'ha5a5_a5a5, '0);
    send(MODE_INSERT, 32'h5555_5555, 48'haaaa_aaaa_aaaa);
    send(MODE_INSERT, 32'haaaa_aaaa, 48'h5555_5555_5555);
    send(MODE_LOOKUP, 32'h5555_5555, '0);
    send(MODE_RSVD, '0, '0);
    send(MODE_TICK, '0, '0);
    // With the timeout lowered to one, the next tick ages every entry past it.
    settle();
    write_timeout(16'd1);
    send(MODE_TICK, '0, '0);
    send(MODE_LOOKUP, '0, '0);
    send(MODE_INSERT, 32'hc0a8_0001, pick_mac());
    // A zero timeout expires an entry on its very first tick.
    settle();
    write_timeout(16'd0);
    send(MODE_TICK, '0, '0);
    send(MODE_LOOKUP, 32'hc0a8_0001, '0);

    // Short timeout: entries come and go all the time.
    settle();
    write_timeout(16'd3);
    run_mix(150, 40, 40, 16);

    // Entries never expire, and inserts dominate, so the table fills up and further
    // inserts are refused.
    settle();
    write_timeout(AGE_MAX);
    run_mix(200, 72, 22, 4);

    // A zero timeout flushes the full table in a single tick.
    settle();
    write_timeout(16'd0);
    send(MODE_TICK, '0, '0);
    run_mix(150, 45, 35, 17);

    // Back-to-back transactions with no idle time on either side.
    settle();
    write_timeout(16'($urandom_range(2, 20)));
    quiet_src  = 1'b1;
    quiet_sink = 1'b1;
    run_mix(150, 50, 38, 10);
    settle();
    quiet_src  = 1'b0;
    quiet_sink = 1'b0;

    // Any timeout at all.
    write_timeout(16'($urandom_range(0, 65535)));
    run_mix(200, 55, 35, 8);

    settle();
    repeat (ENTRIES + 8) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_answers.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
